### sv/pds_pkg.sv
`default_nettype none
package pds_pkg;

    localparam int unsigned PHASE_STEPS = 4;
    localparam int unsigned NUM_FACTOR = (PHASE_STEPS == 0) ? 256 : 256 / PHASE_STEPS;

    localparam int unsigned DIV_W = 41;
    localparam int unsigned DVS_W = 33;
    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam int unsigned NUM_W = 40;

    localparam logic [25:0] REF_CLOCK_RST = 26'd12000000;
    localparam logic [30:0] VCO_MIN_RST   = 31'd400000000;
    localparam logic [31:0] VCO_MAX_RST   = 32'd1600000000;
    localparam logic [30:0] SYS_MAX_RST   = 31'd133000000;

    localparam logic [4:0] RD_FIRST = 5'd1;
    localparam logic [4:0] RD_LAST  = 5'd16;
    localparam logic [8:0] FB_FIRST = 9'd16;
    localparam logic [8:0] FB_LAST  = 9'd320;
    localparam logic [2:0] P_LAST   = 3'd7;
    localparam logic [1:0] K_LAST   = 2'd2;

    localparam logic [1:0] REG_REF_CLOCK = 2'd0;
    localparam logic [1:0] REG_VCO_MIN   = 2'd1;
    localparam logic [1:0] REG_VCO_MAX   = 2'd2;
    localparam logic [1:0] REG_SYS_MAX   = 2'd3;

    localparam logic [1:0] SEL_REF = 2'd0;
    localparam logic [1:0] SEL_CLK = 2'd1;
    localparam logic [1:0] SEL_N   = 2'd2;
    localparam logic [1:0] SEL_FO  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       fref_take;
        logic       vco_take;
        logic       clk_take;
        logic       num_take;
        logic       n_take;
        logic       fo_take;
        logic       commit;
        logic       adv_p;
        logic       adv_fb;
        logic       adv_rd;
        logic       adv_k;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic req_zero;
        logic fref_zero;
        logic vco_ok;
        logic clk_ok;
        logic p_last;
        logic fb_last;
        logic rd_last;
        logic k_last;
        logic win_zero;
    } t_sts;

endpackage
`default_nettype wire

### sv/pds_ifs.sv
`default_nettype none
interface pds_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface pds_req_if;
    logic        valid;
    logic        ready;
    logic [30:0] requested_hz;
    modport source (output valid, output requested_hz, input ready);
    modport sink (input valid, input requested_hz, output ready);
endinterface

interface pds_res_if;
    logic               valid;
    logic               ready;
    logic               pll_found;
    logic [4:0]         ref_divider;
    logic [8:0]         feedback_divider;
    logic [2:0]         post_divider_one;
    logic [2:0]         post_divider_two;
    logic [31:0]        vco_hz;
    logic [30:0]        system_clock_hz;
    logic [15:0]        divider_integer;
    logic [7:0]         divider_fraction;
    logic [31:0]        output_hz;
    logic signed [31:0] error_hz;
    logic [31:0]        error_magnitude_hz;
    modport source (output valid, output pll_found, output ref_divider,
                    output feedback_divider, output post_divider_one,
                    output post_divider_two, output vco_hz, output system_clock_hz,
                    output divider_integer, output divider_fraction, output output_hz,
                    output error_hz, output error_magnitude_hz, input ready);
    modport sink (input valid, input pll_found, input ref_divider,
                  input feedback_divider, input post_divider_one,
                  input post_divider_two, input vco_hz, input system_clock_hz,
                  input divider_integer, input divider_fraction, input output_hz,
                  input error_hz, input error_magnitude_hz, output ready);
endinterface
`default_nettype wire

### sv/pds_ctrl.sv
`default_nettype none
module pds_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    input  pds_pkg::t_sts i_sts,
    output pds_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_REF  = 4'd2;
    localparam logic [3:0] S_REFW = 4'd3;
    localparam logic [3:0] S_FREF = 4'd4;
    localparam logic [3:0] S_VCO  = 4'd5;
    localparam logic [3:0] S_VCHK = 4'd6;
    localparam logic [3:0] S_CLK  = 4'd7;
    localparam logic [3:0] S_CLKW = 4'd8;
    localparam logic [3:0] S_CCHK = 4'd9;
    localparam logic [3:0] S_NDIV = 4'd10;
    localparam logic [3:0] S_NW   = 4'd11;
    localparam logic [3:0] S_FO   = 4'd12;
    localparam logic [3:0] S_FOW  = 4'd13;
    localparam logic [3:0] S_CMP  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       req_p, req_fb, req_rd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        req_p = 1'b0;
        req_fb = 1'b0;
        req_rd = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_sts.req_zero ? S_OUT : S_REF;
            end
            S_REF: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = pds_pkg::SEL_REF;
                n_state = S_REFW;
            end
            S_REFW: begin
                if (i_sts.div_done) begin
                    o_cmd.fref_take = 1'b1;
                    n_state = S_FREF;
                end
            end
            S_FREF: begin
                if (i_sts.fref_zero) begin
                    req_rd = 1'b1;
                end else begin
                    n_state = S_VCO;
                end
            end
            S_VCO: begin
                o_cmd.vco_take = 1'b1;
                n_state = S_VCHK;
            end
            S_VCHK: begin
                if (i_sts.vco_ok) begin
                    n_state = S_CLK;
                end else begin
                    req_fb = 1'b1;
                end
            end
            S_CLK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = pds_pkg::SEL_CLK;
                n_state = S_CLKW;
            end
            S_CLKW: begin
                if (i_sts.div_done) begin
                    o_cmd.clk_take = 1'b1;
                    n_state = S_CCHK;
                end
            end
            S_CCHK: begin
                if (i_sts.clk_ok) begin
                    o_cmd.num_take = 1'b1;
                    n_state = S_NDIV;
                end else begin
                    req_p = 1'b1;
                end
            end
            S_NDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = pds_pkg::SEL_N;
                n_state = S_NW;
            end
            S_NW: begin
                if (i_sts.div_done) begin
                    o_cmd.n_take = 1'b1;
                    n_state = S_FO;
                end
            end
            S_FO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = pds_pkg::SEL_FO;
                n_state = S_FOW;
            end
            S_FOW: begin
                if (i_sts.div_done) begin
                    o_cmd.fo_take = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = S_CMP;
                    end else begin
                        o_cmd.adv_k = 1'b1;
                        n_state = S_FO;
                    end
                end
            end
            S_CMP: begin
                o_cmd.commit = 1'b1;
                if (i_sts.win_zero) begin
                    n_state = S_OUT;
                end else begin
                    req_p = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (req_p) begin
            if (!i_sts.p_last) begin
                o_cmd.adv_p = 1'b1;
                n_state = S_CLK;
            end else begin
                req_fb = 1'b1;
            end
        end
        if (req_fb) begin
            if (!i_sts.fb_last) begin
                o_cmd.adv_fb = 1'b1;
                n_state = S_VCO;
            end else begin
                req_rd = 1'b1;
            end
        end
        if (req_rd) begin
            if (!i_sts.rd_last) begin
                o_cmd.adv_rd = 1'b1;
                n_state = S_REF;
            end else begin
                n_state = S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### sv/pds_dp.sv
`default_nettype none
module pds_dp (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cfg_we,
    input  wire  [1:0]    i_cfg_index,
    input  wire  [31:0]   i_cfg_data,
    input  wire  [30:0]   i_requested_hz,
    input  pds_pkg::t_cmd i_cmd,
    output pds_pkg::t_sts o_sts,
    output logic          o_pll_found,
    output logic [4:0]    o_ref_divider,
    output logic [8:0]    o_feedback_divider,
    output logic [2:0]    o_post_divider_one,
    output logic [2:0]    o_post_divider_two,
    output logic [31:0]   o_vco_hz,
    output logic [30:0]   o_system_clock_hz,
    output logic [15:0]   o_divider_integer,
    output logic [7:0]    o_divider_fraction,
    output logic [31:0]   o_output_hz,
    output logic [31:0]   o_error_hz,
    output logic [31:0]   o_error_magnitude_hz
);

    localparam int unsigned DW = pds_pkg::DIV_W;
    localparam int unsigned VW = pds_pkg::DVS_W;
    localparam int unsigned NW = pds_pkg::NUM_W;

    logic [25:0] r_ref_clock;
    logic [30:0] r_vco_min;
    logic [31:0] r_vco_max;
    logic [30:0] r_sys_max;

    logic [30:0] r_req;
    logic [4:0]  r_rd;
    logic [8:0]  r_fb;
    logic [2:0]  r_p1, r_p2;
    logic [1:0]  r_k;

    logic [25:0] r_fref;
    logic [34:0] r_vco;
    logic [31:0] r_clk;
    logic [NW-1:0] r_num;
    logic [31:0] r_n;

    logic [31:0] r_cfo, r_cerr, r_cmag;
    logic [32:0] r_cn;

    logic        r_found;
    logic [4:0]  r_brd;
    logic [8:0]  r_bfb;
    logic [2:0]  r_bp1, r_bp2;
    logic [31:0] r_bvco;
    logic [30:0] r_bclk;
    logic [31:0] r_bfo, r_berr, r_bmag;
    logic [32:0] r_bn;

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [pds_pkg::CNT_W-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW-1:0] div_a;
    logic [VW-1:0] div_b;
    logic [VW:0]   shifted;
    logic [VW+1:0] diff;
    logic [32:0]   cand_n;
    logic [31:0]   fo, fo_err, fo_mag;
    logic          win;

    always_comb begin
        unique case (r_k)
            2'd0:    cand_n = (r_n > 32'd1) ? {1'b0, r_n - 32'd1} : 33'd1;
            2'd1:    cand_n = {1'b0, r_n};
            default: cand_n = {1'b0, r_n} + 33'd1;
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            pds_pkg::SEL_REF: begin
                div_a = DW'(r_ref_clock);
                div_b = VW'(r_rd);
            end
            pds_pkg::SEL_CLK: begin
                div_a = DW'(r_vco);
                div_b = VW'(6'(r_p1) * 6'(r_p2));
            end
            pds_pkg::SEL_N: begin
                div_a = DW'(r_num) + DW'(r_req[30:1]);
                div_b = VW'(r_req);
            end
            default: begin
                div_a = DW'(r_num);
                div_b = cand_n;
            end
        endcase
    end

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};

    assign fo     = r_quo[31:0];
    assign fo_err = fo - {1'b0, r_req};
    assign fo_mag = fo_err[31] ? (32'd0 - fo_err) : fo_err;
    assign win    = (r_cmag < r_bmag);

    assign o_sts.div_done  = r_done;
    assign o_sts.req_zero  = (r_req == '0);
    assign o_sts.fref_zero = (r_fref == '0);
    assign o_sts.vco_ok    = (r_vco >= 35'(r_vco_min)) && (r_vco <= 35'(r_vco_max));
    assign o_sts.clk_ok    = (r_clk != '0) && (r_clk <= 32'(r_sys_max));
    assign o_sts.p_last    = (r_p1 == pds_pkg::P_LAST) && (r_p2 == pds_pkg::P_LAST);
    assign o_sts.fb_last   = (r_fb == pds_pkg::FB_LAST);
    assign o_sts.rd_last   = (r_rd == pds_pkg::RD_LAST);
    assign o_sts.k_last    = (r_k == pds_pkg::K_LAST);
    assign o_sts.win_zero  = win && (r_cmag == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock <= pds_pkg::REF_CLOCK_RST;
            r_vco_min   <= pds_pkg::VCO_MIN_RST;
            r_vco_max   <= pds_pkg::VCO_MAX_RST;
            r_sys_max   <= pds_pkg::SYS_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pds_pkg::REG_REF_CLOCK: r_ref_clock <= i_cfg_data[25:0];
                pds_pkg::REG_VCO_MIN:   r_vco_min   <= i_cfg_data[30:0];
                pds_pkg::REG_VCO_MAX:   r_vco_max   <= i_cfg_data;
                default:                r_sys_max   <= i_cfg_data[30:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + pds_pkg::CNT_W'(1);
                if (r_cnt == pds_pkg::CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= div_a;
            r_dvs <= div_b;
        end else if (r_busy) begin
            if (!diff[VW+1]) begin
                r_rem <= diff[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= pds_pkg::RD_FIRST;
            r_fb    <= pds_pkg::FB_FIRST;
            r_p1    <= 3'd1;
            r_p2    <= 3'd1;
            r_k     <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd    <= pds_pkg::RD_FIRST;
                r_fb    <= pds_pkg::FB_FIRST;
                r_p1    <= 3'd1;
                r_p2    <= 3'd1;
                r_found <= 1'b0;
            end
            if (i_cmd.adv_rd) begin
                r_rd <= r_rd + 5'd1;
                r_fb <= pds_pkg::FB_FIRST;
                r_p1 <= 3'd1;
                r_p2 <= 3'd1;
            end
            if (i_cmd.adv_fb) begin
                r_fb <= r_fb + 9'd1;
                r_p1 <= 3'd1;
                r_p2 <= 3'd1;
            end
            if (i_cmd.adv_p) begin
                if (r_p2 == r_p1) begin
                    r_p1 <= r_p1 + 3'd1;
                    r_p2 <= 3'd1;
                end else begin
                    r_p2 <= r_p2 + 3'd1;
                end
            end
            if (i_cmd.n_take) begin
                r_k <= '0;
            end else if (i_cmd.adv_k) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.commit && win) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_requested_hz;
            r_bmag <= '1;
        end
        if (i_cmd.fref_take) begin
            r_fref <= r_quo[25:0];
        end
        if (i_cmd.vco_take) begin
            r_vco <= 35'(r_fref) * 35'(r_fb);
        end
        if (i_cmd.clk_take) begin
            r_clk <= r_quo[31:0];
        end
        if (i_cmd.num_take) begin
            r_num <= NW'(r_clk) * NW'(pds_pkg::NUM_FACTOR);
        end
        if (i_cmd.n_take) begin
            r_n    <= (r_quo[31:0] == '0) ? 32'd1 : r_quo[31:0];
            r_cmag <= '1;
        end
        if (i_cmd.fo_take && (fo_mag < r_cmag)) begin
            r_cfo  <= fo;
            r_cerr <= fo_err;
            r_cmag <= fo_mag;
            r_cn   <= cand_n;
        end
        if (i_cmd.commit && win) begin
            r_bfo  <= r_cfo;
            r_berr <= r_cerr;
            r_bmag <= r_cmag;
            r_bn   <= r_cn;
            r_brd  <= r_rd;
            r_bfb  <= r_fb;
            r_bp1  <= r_p1;
            r_bp2  <= r_p2;
            r_bvco <= r_vco[31:0];
            r_bclk <= r_clk[30:0];
        end
        if (i_cmd.out_load) begin
            o_pll_found          <= r_found;
            o_ref_divider        <= r_found ? r_brd : '0;
            o_feedback_divider   <= r_found ? r_bfb : '0;
            o_post_divider_one   <= r_found ? r_bp1 : '0;
            o_post_divider_two   <= r_found ? r_bp2 : '0;
            o_vco_hz             <= r_found ? r_bvco : '0;
            o_system_clock_hz    <= r_found ? r_bclk : '0;
            o_divider_integer    <= r_found ? r_bn[23:8] : '0;
            o_divider_fraction   <= r_found ? r_bn[7:0] : '0;
            o_output_hz          <= r_found ? r_bfo : '0;
            o_error_hz           <= r_found ? r_berr : '0;
            o_error_magnitude_hz <= r_found ? r_bmag : '0;
        end
    end

endmodule
`default_nettype wire

### sv/pll_and_divider_search.sv
`default_nettype none
// Channel   Dir  Payload
// i_cfg     in   index (2), data (32): register write, always ready
// i_req     in   requested_hz (31)
// o_res     out  found flag, dividers, vco, clock, Q16.8 divider, output, error
// One request walks every PLL setting, each division done in the shared
// bit-serial divider; a zero-error setting ends the walk early.
// Reset restores the register defaults. A finished word holds on o_res until
// taken; the next request is accepted once the search hands its word over.
module pll_and_divider_search (
    input  wire i_clk,
    input  wire i_rst_n,
    pds_cfg_if.sink   i_cfg,
    pds_req_if.sink   i_req,
    pds_res_if.source o_res
);

    pds_pkg::t_cmd cmd;
    pds_pkg::t_sts sts;
    logic [31:0]   err;

    assign i_cfg.ready = 1'b1;
    assign o_res.error_hz = $signed(err);

    pds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pds_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg.valid),
        .i_cfg_index          (i_cfg.index),
        .i_cfg_data           (i_cfg.data),
        .i_requested_hz       (i_req.requested_hz),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_pll_found          (o_res.pll_found),
        .o_ref_divider        (o_res.ref_divider),
        .o_feedback_divider   (o_res.feedback_divider),
        .o_post_divider_one   (o_res.post_divider_one),
        .o_post_divider_two   (o_res.post_divider_two),
        .o_vco_hz             (o_res.vco_hz),
        .o_system_clock_hz    (o_res.system_clock_hz),
        .o_divider_integer    (o_res.divider_integer),
        .o_divider_fraction   (o_res.divider_fraction),
        .o_output_hz          (o_res.output_hz),
        .o_error_hz           (err),
        .o_error_magnitude_hz (o_res.error_magnitude_hz)
    );

endmodule
`default_nettype wire
